// ===== design/alat_pkg.sv =====
// Shared types and constants for the audio level detector with automatic threshold.
// No dependencies; the front end, queue, core and top level import this package.
package alat_pkg;

    // Input operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CALL = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PERIOD   = 3'd4;

    // Register reset values.
    localparam logic        RST_AUTO_GAIN     = 1'b0;
    localparam logic [3:0]  RST_SENSITIVITY   = 4'd5;
    localparam logic [9:0]  RST_THRESHOLD     = 10'd100;
    localparam logic [7:0]  RST_READ_INTERVAL = 8'd10;
    localparam logic [15:0] RST_GAIN_PERIOD   = 16'd1000;

    // Arithmetic constants.
    localparam logic [11:0] MIDSCALE    = 12'd2048;
    localparam logic [10:0] SENS_SCALE  = 11'd100;
    localparam logic [12:0] RANGE_MIN   = 13'd50;
    localparam logic [12:0] THR_LO      = 13'd50;
    localparam logic [12:0] THR_HI      = 13'd500;
    localparam logic [12:0] TRACK_STEP  = 13'd10;
    localparam logic [12:0] TRACK_MAX   = 13'd8191;
    localparam logic [12:0] FLOOR_RESET = 13'd2048;
    localparam logic [15:0] CNT_MAX     = 16'hFFFF;

    // Classified item as it travels from the front end to the core.
    typedef struct packed {
        logic        is_call;
        logic [11:0] level;
    } alat_item_t;

    // Static configuration seen by the core.
    typedef struct packed {
        logic        auto_gain;
        logic [10:0] sens_factor;
        logic [7:0]  read_interval;
        logic [15:0] gain_period;
    } alat_cfg_t;

    // Load strobe for the working threshold.
    typedef struct packed {
        logic       load;
        logic [9:0] value;
    } alat_thr_load_t;

endpackage

// ===== design/alat_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
interface alat_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [11:0] adc_sample;

    modport source (output valid, output opcode, output adc_sample, input ready);
    modport sink (input valid, input opcode, input adc_sample, output ready);
endinterface

interface alat_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] scaled_level;
    logic [11:0] raw_level;
    logic [11:0] average_level;
    logic [9:0]  threshold;

    modport source (output valid, output scaled_level, output raw_level,
                    output average_level, output threshold, input ready);
    modport sink (input valid, input scaled_level, input raw_level,
                  input average_level, input threshold, output ready);
    modport mon (input valid, input ready, input scaled_level, input raw_level,
                 input average_level, input threshold);
endinterface

// ===== design/alat_front.sv =====
// Front end: accepts input beats, classifies them and precomputes the sample level.
// Depends on alat_pkg and alat_in_if.
module alat_front (
    input  logic                clk,
    input  logic                rst_n,
    alat_in_if.sink             item,
    output logic                push,
    output alat_pkg::alat_item_t push_item,
    input  logic                full
);
    import alat_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    alat_item_t item_reg;
    logic       accept;
    logic [11:0] level;

    assign item.ready = !valid_reg || !full;
    assign accept     = item.valid && item.ready;
    assign push       = valid_reg && !full;
    assign push_item  = item_reg;

    // Absolute deviation from midscale.
    assign level = (item.adc_sample >= MIDSCALE) ? (item.adc_sample - MIDSCALE)
                                                 : (MIDSCALE - item.adc_sample);

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.is_call <= (item.opcode == OP_CALL);
            item_reg.level   <= level;
        end
    end

endmodule

// ===== design/alat_queue.sv =====
// Two-entry queue that decouples the front end from the core.
// Depends on alat_pkg.
module alat_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  alat_pkg::alat_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output alat_pkg::alat_item_t head_item
);
    import alat_pkg::*;

    alat_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/alat_core.sv =====
// Back end: state update (read timing, ring average, min/max tracking) and result register.
// Depends on alat_pkg and alat_out_if.
module alat_core #(
    parameter int AVG_DEPTH = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  alat_pkg::alat_item_t    head_item,
    output logic                    pop,
    input  alat_pkg::alat_cfg_t     cfg,
    input  alat_pkg::alat_thr_load_t thr_load,
    alat_out_if.source              result
);
    import alat_pkg::*;

    localparam int PTR_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W   = $clog2(2048 * AVG_DEPTH + 1);
    localparam int DIV_SH  = SUM_W + $clog2(AVG_DEPTH);
    localparam int RECIP_W = SUM_W + 2;
    // Rounded-up reciprocal: exact floor division for every sum below 2**SUM_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

    // State registers.
    logic [15:0]      ms_read_reg, ms_read_next;
    logic [15:0]      ms_gain_reg, ms_gain_next;
    logic [11:0]      held_reg, held_next;
    logic [12:0]      floor_reg, floor_next;
    logic [12:0]      ceil_reg, ceil_next;
    logic [9:0]       thr_reg, thr_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [AVG_DEPTH-1:0] filled_reg;
    logic             old_valid_reg;
    logic [11:0]      old_data_reg;
    logic [11:0]      ring_mem [AVG_DEPTH];

    // Stage handshakes.
    logic a_valid_reg, a_valid_next;
    logic out_valid_reg, out_valid_next;
    logic b_ready, b_take, a_ready;

    // Result registers.
    logic [10:0] scaled_reg;
    logic [11:0] raw_reg;
    logic [11:0] avg_reg;
    logic [9:0]  thr_out_reg;

    // Datapath.
    logic        tick, call, new_read, track, gain_due, adapt;
    logic [12:0] held_ext, floor_t, ceil_t, range, thr_sum, thr_clamp;
    logic [13:0] floor_step;
    logic [PTR_W-1:0] ptr_adv;
    logic [11:0] old_level;
    logic [22:0] scaled_prod;
    logic [11:0] scaled_full;
    logic [10:0] cap;
    logic [10:0] scaled_out;
    logic [SUM_W+RECIP_W-1:0] avg_prod;

    assign b_ready = !out_valid_reg || result.ready;
    assign b_take  = a_valid_reg && b_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = head_valid && (!head_item.is_call || a_ready);
    assign tick    = pop && !head_item.is_call;
    assign call    = pop && head_item.is_call;

    always_comb
    begin
        new_read  = call && (ms_read_reg > {8'd0, cfg.read_interval});
        held_next = new_read ? head_item.level : held_reg;
        held_ext  = {1'b0, held_next};
        track     = new_read && cfg.auto_gain;
        floor_t   = (track && (held_ext < floor_reg)) ? held_ext : floor_reg;
        ceil_t    = (track && (held_ext > ceil_reg)) ? held_ext : ceil_reg;
        gain_due  = track && (ms_gain_reg > cfg.gain_period);
        range     = ceil_t - floor_t;
        adapt     = gain_due && (ceil_t > floor_t) && (range > RANGE_MIN);
        thr_sum   = floor_t + {1'b0, range[12:1]};
        if (thr_sum < THR_LO)
        begin
            thr_clamp = THR_LO;
        end
        else if (thr_sum > THR_HI)
        begin
            thr_clamp = THR_HI;
        end
        else
        begin
            thr_clamp = thr_sum;
        end
        floor_step = {1'b0, floor_t} + {1'b0, TRACK_STEP};

        floor_next = floor_t;
        ceil_next  = ceil_t;
        if (adapt)
        begin
            floor_next = (floor_step > {1'b0, TRACK_MAX}) ? TRACK_MAX : floor_step[12:0];
            ceil_next  = (ceil_t < TRACK_STEP) ? 13'd0 : (ceil_t - TRACK_STEP);
        end

        thr_next = thr_reg;
        if (thr_load.load)
        begin
            thr_next = thr_load.value;
        end
        else if (adapt)
        begin
            thr_next = thr_clamp[9:0];
        end

        ms_read_next = ms_read_reg;
        ms_gain_next = ms_gain_reg;
        if (tick)
        begin
            if (ms_read_reg != CNT_MAX)
            begin
                ms_read_next = ms_read_reg + 16'd1;
            end
            if (ms_gain_reg != CNT_MAX)
            begin
                ms_gain_next = ms_gain_reg + 16'd1;
            end
        end
        if (new_read)
        begin
            ms_read_next = 16'd0;
        end
        if (gain_due)
        begin
            ms_gain_next = 16'd0;
        end

        // Ring: replace the oldest entry, which was read ahead into old_data_reg.
        old_level  = old_valid_reg ? old_data_reg : 12'd0;
        ptr_adv    = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
        ptr_next   = call ? ptr_adv : ptr_reg;
        total_next = call ? (total_reg - SUM_W'(old_level) + SUM_W'(held_next)) : total_reg;

        a_valid_next = call ? 1'b1 : (b_take ? 1'b0 : a_valid_reg);
        out_valid_next = b_take ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    // Result stage arithmetic from the registered state.
    always_comb
    begin
        scaled_prod = 23'(held_reg) * 23'(cfg.sens_factor);
        scaled_full = scaled_prod[22:11];
        cap         = {thr_reg, 1'b0};
        scaled_out  = ({1'b0, cap} < scaled_full) ? cap : scaled_full[10:0];
        avg_prod    = (SUM_W+RECIP_W)'(total_reg) * (SUM_W+RECIP_W)'(RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_read_reg   <= 16'd0;
            ms_gain_reg   <= 16'd0;
            held_reg      <= 12'd0;
            floor_reg     <= FLOOR_RESET;
            ceil_reg      <= 13'd0;
            thr_reg       <= RST_THRESHOLD;
            ptr_reg       <= '0;
            total_reg     <= '0;
            filled_reg    <= '0;
            old_valid_reg <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ms_read_reg   <= ms_read_next;
            ms_gain_reg   <= ms_gain_next;
            held_reg      <= held_next;
            floor_reg     <= floor_next;
            ceil_reg      <= ceil_next;
            thr_reg       <= thr_next;
            ptr_reg       <= ptr_next;
            total_reg     <= total_next;
            if (call)
            begin
                filled_reg[ptr_reg] <= 1'b1;
            end
            old_valid_reg <= filled_reg[ptr_next];
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (call)
        begin
            ring_mem[ptr_reg] <= held_next;
        end
        old_data_reg <= ring_mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (b_take)
        begin
            scaled_reg  <= scaled_out;
            raw_reg     <= held_reg;
            avg_reg     <= avg_prod[DIV_SH +: 12];
            thr_out_reg <= thr_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.scaled_level  = scaled_reg;
    assign result.raw_level     = raw_reg;
    assign result.average_level = avg_reg;
    assign result.threshold     = thr_out_reg;

endmodule

// ===== design/audio_level_auto_threshold_unit.sv =====
// Audio level detector with moving average and automatic threshold: top level.
// A process call passes through the front-end register, the queue, the core's state and the result register.
// The block takes one item per cycle unless a waiting result stalls process calls; the core updates all state at once.
// Reset (rst_n, asynchronous, active low) restores the control and state registers and marks the ring empty.
// Depends on alat_pkg, alat_if, alat_front, alat_queue and alat_core.
module audio_level_auto_threshold_unit #(
    parameter int AVG_DEPTH = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    alat_in_if.sink                            item,
    alat_out_if.source                         result,
    input  logic                               cfg_write,
    input  logic [alat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [alat_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import alat_pkg::*;

    // The block is split into three parts. The front end takes input beats,
    // decides whether each is a millisecond tick or a process call and works
    // out the sample's deviation from midscale. A two-entry queue sits between
    // it and the core so that a stall on the result side does not at once
    // reach the input, and ticks keep draining even while a result waits.
    // The core holds all of the detector's state and a result register.

    // Configuration registers. The sensitivity is kept pre-multiplied by one
    // hundred, so scaling a level in the core needs only one multiplication.
    logic        auto_gain_reg;
    logic [10:0] sens_factor_reg;
    logic [7:0]  read_interval_reg;
    logic [15:0] gain_period_reg;

    alat_cfg_t      cfg;
    alat_thr_load_t thr_load;

    logic       push, full, pop, head_valid;
    alat_item_t push_item, head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_gain_reg     <= RST_AUTO_GAIN;
            sens_factor_reg   <= 11'(RST_SENSITIVITY) * SENS_SCALE;
            read_interval_reg <= RST_READ_INTERVAL;
            gain_period_reg   <= RST_GAIN_PERIOD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AUTO_GAIN:     auto_gain_reg     <= cfg_data[0];
                REG_SENSITIVITY:   sens_factor_reg   <= 11'(cfg_data[3:0]) * SENS_SCALE;
                REG_READ_INTERVAL: read_interval_reg <= cfg_data[7:0];
                REG_GAIN_PERIOD:   gain_period_reg   <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // Writing the threshold setting loads the working threshold directly;
    // nothing else reads the setting afterwards.
    assign thr_load.load  = cfg_write && (cfg_index == REG_THRESHOLD);
    assign thr_load.value = cfg_data[9:0];

    assign cfg.auto_gain     = auto_gain_reg;
    assign cfg.sens_factor   = sens_factor_reg;
    assign cfg.read_interval = read_interval_reg;
    assign cfg.gain_period   = gain_period_reg;

    alat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    alat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    alat_core #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .cfg        (cfg),
        .thr_load   (thr_load),
        .result     (result)
    );

endmodule

// ===== design/alat_checker.sv =====
// Port-level checks on the result channel of the level detector, and their binding.
// Depends on audio_level_auto_threshold_unit and its result interface.
module alat_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [10:0] scaled_level,
    input  logic [11:0] raw_level,
    input  logic [11:0] average_level,
    input  logic [9:0]  threshold
);

    // A waiting result holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(raw_level)
            && $stable(scaled_level) && $stable(average_level)
            && $stable(threshold))
        else $error("result changed while stalled");

    // A result leaves only through a handshake.
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(result_ready))
        else $error("result dropped without handshake");

    // The scaled level never exceeds twice the reported threshold.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> scaled_level <= {threshold, 1'b0})
        else $error("scaled level above clamp");

    // Levels and their average stay within the converter's half range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (raw_level <= 12'd2048) && (average_level <= 12'd2048))
        else $error("level out of range");

endmodule

bind audio_level_auto_threshold_unit alat_checker u_alat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .scaled_level  (result.scaled_level),
    .raw_level     (result.raw_level),
    .average_level (result.average_level),
    .threshold     (result.threshold)
);
